@@ rtl/core/eit_pkg.sv @@
// ----------------------------------------------------------------------------
// eit_pkg: shared types and constants for the event interest table
// Mode and status codes, event bit positions, and the item carried from the
// front end to the table engine.
// ----------------------------------------------------------------------------
package eit_pkg;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_MOD    = 2'd1;
  localparam logic [1:0] MODE_DEL    = 2'd2;
  localparam logic [1:0] MODE_SAMPLE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EXISTS  = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [31:0] EV_ERR     = 32'h0000_0008;
  localparam logic [31:0] EV_HUP     = 32'h0000_0010;
  localparam logic [31:0] EV_RDHUP   = 32'h0000_2000;
  localparam logic [31:0] EV_ONESHOT = 32'h4000_0000;
  localparam logic [31:0] EV_ET      = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] descriptor;
    logic [31:0] interest_mask;
    logic [63:0] user_tag;
    logic [31:0] ready_mask;
  } eit_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        event_valid;
    logic [31:0] reported_mask;
    logic [63:0] event_tag;
    logic [4:0]  entry_count;
  } eit_rsp_t;

endpackage

@@ rtl/core/eit_front.sv @@
// ----------------------------------------------------------------------------
// eit_front: input stage and command queue
// Accepts items, folds the bad-descriptor flag into the ready mask and holds
// them in a short queue ahead of the table engine.
// ----------------------------------------------------------------------------
module eit_front import eit_pkg::*; #(
  parameter int QDEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_descriptor,
  input  logic [31:0] in_interest_mask,
  input  logic [63:0] in_user_tag,
  input  logic [31:0] in_ready_mask,
  input  logic        in_bad_descriptor,
  output logic        cmd_valid,
  input  logic        cmd_take,
  output eit_cmd_t    cmd
);
  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  eit_cmd_t         q_r [QDEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;
  eit_cmd_t         c_in;
  logic             do_push, do_pop;

  always_comb begin
    c_in.mode          = in_mode;
    c_in.descriptor    = in_descriptor;
    c_in.interest_mask = in_interest_mask;
    c_in.user_tag      = in_user_tag;
    c_in.ready_mask    = in_bad_descriptor ? (EV_ERR | EV_HUP) : in_ready_mask;
  end

  assign full      = (cnt_r == (AW+1)'(QDEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_valid && cmd_take;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= c_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == AW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

@@ rtl/core/eit_engine.sv @@
// ----------------------------------------------------------------------------
// eit_engine: table engine
// Searches the table one entry a cycle, applies the command and shifts
// entries down one a cycle on delete. The result is staged, then moved to a
// one-entry output reg once that is free.
// ----------------------------------------------------------------------------
module eit_engine import eit_pkg::*; #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  output logic     cmd_take,
  input  eit_cmd_t cmd,
  output logic     empty,
  input  logic     pop,
  output eit_rsp_t rsp
);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [KEY_BITS-1:0] key_m  [MAX_ENTRIES];
  logic [31:0]         int_m  [MAX_ENTRIES];
  logic [31:0]         lr_m   [MAX_ENTRIES];
  logic [63:0]         tag_m  [MAX_ENTRIES];

  logic [1:0]    state_r;
  eit_cmd_t      c_r;
  logic [CW-1:0] idx_r, count_r;
  logic          out_v_r;
  eit_rsp_t      res_r;
  eit_rsp_t      out_r;

  logic [IW-1:0]       ix;
  logic [IW-1:0]       ix1;
  logic [KEY_BITS-1:0] ckey;
  logic                at_end, hit_key;
  logic [31:0]         ev, hitm, rep;

  assign ix      = idx_r[IW-1:0];
  assign ix1     = IW'(idx_r + CW'(1));
  assign ckey    = KEY_BITS'(c_r.descriptor);
  assign at_end  = (idx_r >= count_r);
  assign hit_key = !at_end && (key_m[ix] == ckey);
  assign ev      = int_m[ix];
  assign hitm    = c_r.ready_mask & (ev | EV_ERR | EV_HUP | EV_RDHUP);
  assign rep     = (ev & EV_ET) != '0 ? (hitm & ~lr_m[ix]) : hitm;

  assign cmd_take = (state_r == S_IDLE) && cmd_valid;
  assign empty    = !out_v_r;
  assign rsp      = out_r;

  always_ff @(posedge clk) begin
    if (state_r == S_SEARCH && !at_end && !hit_key) begin
    end else if (state_r == S_SEARCH && at_end && c_r.mode == MODE_ADD
                 && count_r < CW'(MAX_ENTRIES)) begin
      key_m[ix] <= ckey;
      int_m[ix] <= c_r.interest_mask;
      lr_m[ix]  <= '0;
      tag_m[ix] <= c_r.user_tag;
    end else if (state_r == S_SEARCH && hit_key && c_r.mode == MODE_MOD) begin
      int_m[ix] <= c_r.interest_mask;
      lr_m[ix]  <= '0;
      tag_m[ix] <= c_r.user_tag;
    end else if (state_r == S_SEARCH && hit_key && c_r.mode == MODE_SAMPLE) begin
      if (rep != '0 && (ev & EV_ONESHOT) != '0) begin
        int_m[ix] <= '0;
        lr_m[ix]  <= '0;
      end else if ((ev & EV_ET) != '0) begin
        lr_m[ix]  <= hitm;
      end
    end else if (state_r == S_SHIFT && idx_r + CW'(1) < count_r) begin
      key_m[ix] <= key_m[ix1];
      int_m[ix] <= int_m[ix1];
      lr_m[ix]  <= lr_m[ix1];
      tag_m[ix] <= tag_m[ix1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      count_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      // staged result moves out only once the output reg is free
      if (state_r == S_DONE && (!out_v_r || pop)) begin
        out_v_r <= 1'b1;
        out_r   <= res_r;
      end else if (pop && out_v_r) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            c_r     <= cmd;
            idx_r   <= '0;
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          res_r.status        <= ST_OK;
          res_r.event_valid   <= 1'b0;
          res_r.reported_mask <= '0;
          res_r.event_tag     <= '0;
          res_r.entry_count   <= 5'(count_r);
          if (at_end) begin
            if (c_r.mode != MODE_ADD) begin
              res_r.status <= ST_MISSING;
            end else if (count_r >= CW'(MAX_ENTRIES)) begin
              res_r.status <= ST_FULL;
            end else begin
              count_r           <= count_r + CW'(1);
              res_r.entry_count <= 5'(count_r + CW'(1));
            end
            state_r <= S_DONE;
          end else if (hit_key) begin
            case (c_r.mode)
              MODE_ADD: begin
                res_r.status <= ST_EXISTS;
                state_r      <= S_DONE;
              end
              MODE_DEL: begin
                res_r.entry_count <= 5'(count_r - CW'(1));
                state_r           <= S_SHIFT;
              end
              MODE_SAMPLE: begin
                if (rep != '0) begin
                  res_r.event_valid   <= 1'b1;
                  res_r.reported_mask <= rep;
                  res_r.event_tag     <= tag_m[ix];
                end
                state_r <= S_DONE;
              end
              default: state_r <= S_DONE;
            endcase
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        S_SHIFT: begin
          if (idx_r + CW'(1) < count_r) begin
            idx_r <= idx_r + CW'(1);
          end else begin
            count_r <= count_r - CW'(1);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_v_r || pop) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/event_interest_table.sv @@
// ----------------------------------------------------------------------------
// event_interest_table: ordered table of watched descriptors
// Add, modify, delete and readiness sampling in the style of an interest list.
// ----------------------------------------------------------------------------
// Usage:
//  Input side is a queue: drive in_* and push; the item is taken when full is
//  low. Every item gives exactly one result on out_*, shown while empty is
//  low and taken with pop.
//  Items enter a two-deep command queue; the table engine takes one at a
//  time. It scans entries one a cycle to find the key, or to the end of the
//  table when the key is absent; a delete then shifts each entry behind the
//  removed one down one place.
//  Reset empties the table and both queues; entry contents are not cleared.
//  If pop stays low the finished result is held, the engine stalls once its
//  next result is ready, and full rises when the command queue fills.
// ----------------------------------------------------------------------------
module event_interest_table import eit_pkg::*; #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_descriptor,
  input  logic [31:0] in_interest_mask,
  input  logic [63:0] in_user_tag,
  input  logic [31:0] in_ready_mask,
  input  logic        in_bad_descriptor,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_status,
  output logic        out_event_valid,
  output logic [31:0] out_reported_mask,
  output logic [63:0] out_event_tag,
  output logic [4:0]  out_entry_count
);
  logic     cmd_valid, cmd_take;
  eit_cmd_t cmd;
  eit_rsp_t rsp;

  eit_front #(.QDEPTH(2)) u_front (
    .clk, .rst_n, .push, .full,
    .in_mode, .in_descriptor, .in_interest_mask, .in_user_tag,
    .in_ready_mask, .in_bad_descriptor,
    .cmd_valid, .cmd_take, .cmd
  );

  eit_engine #(.MAX_ENTRIES(MAX_ENTRIES), .KEY_BITS(KEY_BITS)) u_engine (
    .clk, .rst_n, .cmd_valid, .cmd_take, .cmd, .empty, .pop, .rsp
  );

  assign out_status        = rsp.status;
  assign out_event_valid   = rsp.event_valid;
  assign out_reported_mask = rsp.reported_mask;
  assign out_event_tag     = rsp.event_tag;
  assign out_entry_count   = rsp.entry_count;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_entry_count <= 5'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_event_valid) |-> (out_reported_mask == '0))
    else $error("report without event");

  a_event_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_event_valid) |-> (out_status == ST_OK && out_reported_mask != '0))
    else $error("event with bad status");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_event_tag)))
    else $error("result dropped while stalled");

endmodule

@@ test/event_interest_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_interest_table_tb: self-checking bench for the event interest table
// Directed and random add/modify/delete/sample items are pushed with random
// gaps. A behavioural copy of the table predicts each result, and a separate
// process pops results with random stalls and compares them field by field.
// ----------------------------------------------------------------------------
module event_interest_table_tb;
  import eit_pkg::*;

  localparam int NUM_ENTRIES = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_mode = MODE_ADD;
  logic [15:0] in_descriptor = '0;
  logic [31:0] in_interest_mask = '0;
  logic [63:0] in_user_tag = '0;
  logic [31:0] in_ready_mask = '0;
  logic        in_bad_descriptor = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_status;
  logic        out_event_valid;
  logic [31:0] out_reported_mask;
  logic [63:0] out_event_tag;
  logic [4:0]  out_entry_count;

  event_interest_table u_top (.*);

  always #2 clk = ~clk;

  // predicted table
  logic [15:0] tbl_key [NUM_ENTRIES];
  logic [31:0] tbl_interest [NUM_ENTRIES];
  logic [31:0] tbl_last [NUM_ENTRIES];
  logic [63:0] tbl_tag [NUM_ENTRIES];
  int          tbl_count = 0;

  eit_rsp_t expected_rsps[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  hold_pop = 1'b0;
  int  hold_cycles = 0;

  function automatic eit_rsp_t apply_item(logic [1:0] mode, logic [15:0] key,
                                          logic [31:0] mask, logic [63:0] tag,
                                          logic [31:0] ready, logic bad);
    eit_rsp_t r;
    int idx;
    logic [31:0] ev, hit, rep;
    r = '0;
    idx = -1;
    for (int i = 0; i < tbl_count; i++)
      if (idx < 0 && tbl_key[i] == key) idx = i;
    if (mode == MODE_ADD) begin
      if (idx >= 0) r.status = ST_EXISTS;
      else if (tbl_count >= NUM_ENTRIES) r.status = ST_FULL;
      else begin
        tbl_key[tbl_count] = key;
        tbl_interest[tbl_count] = mask;
        tbl_last[tbl_count] = '0;
        tbl_tag[tbl_count] = tag;
        tbl_count++;
      end
    end else if (idx < 0) begin
      r.status = ST_MISSING;
    end else if (mode == MODE_MOD) begin
      tbl_interest[idx] = mask;
      tbl_last[idx] = '0;
      tbl_tag[idx] = tag;
    end else if (mode == MODE_DEL) begin
      for (int i = idx; i + 1 < tbl_count; i++) begin
        tbl_key[i] = tbl_key[i+1];
        tbl_interest[i] = tbl_interest[i+1];
        tbl_last[i] = tbl_last[i+1];
        tbl_tag[i] = tbl_tag[i+1];
      end
      tbl_count--;
    end else begin
      ev = tbl_interest[idx];
      if (bad) ready = EV_ERR | EV_HUP;
      hit = ready & (ev | EV_ERR | EV_HUP | EV_RDHUP);
      if (ev & EV_ET) begin
        rep = hit & ~tbl_last[idx];
        tbl_last[idx] = hit;
      end else begin
        rep = hit;
      end
      if (rep != '0) begin
        r.event_valid = 1'b1;
        r.reported_mask = rep;
        r.event_tag = tbl_tag[idx];
        if (ev & EV_ONESHOT) begin
          tbl_interest[idx] = '0;
          tbl_last[idx] = '0;
        end
      end
    end
    r.entry_count = 5'(tbl_count);
    return r;
  endfunction

  // called at a falling edge; returns at a falling edge with push still high
  // when no gap follows
  task automatic send_item(logic [1:0] mode, logic [15:0] key, logic [31:0] mask,
                           logic [63:0] tag, logic [31:0] ready, logic bad);
    int gap;
    push <= 1'b1;
    in_mode <= mode;
    in_descriptor <= key;
    in_interest_mask <= mask;
    in_user_tag <= tag;
    in_ready_mask <= ready;
    in_bad_descriptor <= bad;
    do @(posedge clk); while (full);
    expected_rsps.push_back(apply_item(mode, key, mask, tag, ready, bad));
    @(negedge clk);
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic stop_items();
    push <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand_tag();
    return {$urandom(), $urandom()};
  endfunction

  // result side: random stalls, plus a long hold when asked
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      while (hold_pop) begin
        pop <= 1'b0;
        @(negedge clk);
      end
      stall = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (expected_rsps.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        eit_rsp_t e;
        e = expected_rsps.pop_front();
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); errors++;
        end
        if (out_event_valid !== e.event_valid) begin
          $error("event_valid exp %0d got %0d", e.event_valid, out_event_valid);
          errors++;
        end
        if (out_reported_mask !== e.reported_mask) begin
          $error("reported_mask exp %h got %h", e.reported_mask, out_reported_mask);
          errors++;
        end
        if (out_event_tag !== e.event_tag) begin
          $error("event_tag exp %h got %h", e.event_tag, out_event_tag); errors++;
        end
        if (out_entry_count !== e.entry_count) begin
          $error("entry_count exp %0d got %0d", e.entry_count, out_entry_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || hold_pop) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk)
    if (hold_pop) begin
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles >= 120) hold_pop <= 1'b0;
    end

  task automatic test_directed();
    send_item(MODE_SAMPLE, 16'h0000, '0, '0, '1, 1'b0);   // sample on empty table
    send_item(MODE_MOD, 16'hFFFF, '1, '1, '0, 1'b0);      // modify missing
    send_item(MODE_DEL, 16'h1234, '0, '0, '0, 1'b0);      // delete missing
    send_item(MODE_ADD, 16'h0000, 32'h0000_0001, 64'h0, '0, 1'b0);
    send_item(MODE_ADD, 16'hFFFF, EV_ET | 32'h1, '1, '0, 1'b0);
    send_item(MODE_ADD, 16'h0000, '1, '1, '0, 1'b0);      // duplicate
    send_item(MODE_ADD, 16'h00A5, EV_ONESHOT | 32'h4, 64'hDEAD_BEEF_0123_4567, '0, 1'b0);
    send_item(MODE_SAMPLE, 16'h0000, '0, '0, '1, 1'b0);
    send_item(MODE_SAMPLE, 16'h0000, '0, '0, '0, 1'b0);   // nothing to report
    send_item(MODE_SAMPLE, 16'hFFFF, '0, '0, 32'h1, 1'b0);
    send_item(MODE_SAMPLE, 16'hFFFF, '0, '0, 32'h1, 1'b0); // edge: no new bits
    send_item(MODE_SAMPLE, 16'hFFFF, '0, '0, 32'h0, 1'b1); // bad descriptor
    send_item(MODE_SAMPLE, 16'h00A5, '0, '0, 32'h4, 1'b0); // one-shot fires
    send_item(MODE_SAMPLE, 16'h00A5, '0, '0, 32'h4, 1'b0); // disarmed
    send_item(MODE_SAMPLE, 16'h00A5, '0, '0, EV_RDHUP, 1'b0);
    send_item(MODE_MOD, 16'hFFFF, '1, 64'h5555_AAAA_5555_AAAA, '0, 1'b0);
    send_item(MODE_SAMPLE, 16'hFFFF, '0, '0, '1, 1'b0);
    send_item(MODE_DEL, 16'h0000, '0, '0, '0, 1'b0);      // delete front, compaction
    send_item(MODE_SAMPLE, 16'h00A5, '0, '0, '1, 1'b0);
    for (int i = 0; i < NUM_ENTRIES; i++)
      send_item(MODE_ADD, 16'(16'h0100 + i), $urandom(), rand_tag(), '0, 1'b0);
    send_item(MODE_DEL, 16'h00A5, '0, '0, '0, 1'b0);
    stop_items();
  endtask

  task automatic test_backpressure();
    hold_cycles = 0;
    hold_pop = 1'b1;
    for (int i = 0; i < 12; i++)
      send_item(MODE_SAMPLE, 16'(16'h0100 + i), '0, '0, $urandom(), 1'b0);
    stop_items();
    wait (!hold_pop);
  endtask

  task automatic test_random(int n);
    logic [15:0] key;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (tbl_count > 0 && pick < 8)
        key = tbl_key[$urandom_range(0, tbl_count - 1)];
      else if (pick == 8) key = 16'($urandom());
      else key = 16'($urandom_range(0, 23));
      case ($urandom_range(0, 9))
        0, 1:    send_item(MODE_ADD, key, $urandom(), rand_tag(), $urandom(), 1'($urandom()));
        2:       send_item(MODE_MOD, key, $urandom(), rand_tag(), $urandom(), 1'($urandom()));
        3, 4:    send_item(MODE_DEL, key, $urandom(), rand_tag(), $urandom(), 1'($urandom()));
        default: send_item(MODE_SAMPLE, key, $urandom(), rand_tag(),
                           $urandom() & ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_201F),
                           ($urandom_range(0, 7) == 0));
      endcase
    end
    stop_items();
  endtask

  initial begin
    int waited;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random(1850);
    waited = 0;
    while (expected_rsps.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (40) @(negedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/eit_pkg.sv
rtl/core/eit_front.sv
rtl/core/eit_engine.sv
rtl/core/event_interest_table.sv
test/event_interest_table_tb.sv
